// ----- design/irqtq_pkg.sv -----
// Shared types and constants for the interrupt task queue.
// Holds the entry layout, the classified insert request and the result beat.
// No dependencies.
package irqtq_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;

    localparam int PRIO_W = 4;
    localparam int KIND_W = 2;
    localparam int ACK_W  = 2;
    localparam int CNT_OUT_W = 4;
    localparam int CFG_IDX_W = 2;

    localparam int UART_PENDING_BIT = 29;
    localparam logic [7:0]  UART_RX_IDENT  = 8'h04;
    localparam logic [7:0]  UART_TX_IDENT  = 8'h02;
    localparam logic [11:0] CORE_TIMER_BIT = 12'h002;

    localparam logic [KIND_W-1:0] KIND_RX    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TX    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TIMER = 2'd2;

    localparam logic [ACK_W-1:0] ACK_NONE  = 2'd0;
    localparam logic [ACK_W-1:0] ACK_RX    = 2'd1;
    localparam logic [ACK_W-1:0] ACK_TX    = 2'd2;
    localparam logic [ACK_W-1:0] ACK_TIMER = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_RX_PRIO    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_PRIO    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_PRIO = 2'd2;

    localparam logic [PRIO_W-1:0] RX_PRIO_RST    = 4'd3;
    localparam logic [PRIO_W-1:0] TX_PRIO_RST    = 4'd3;
    localparam logic [PRIO_W-1:0] TIMER_PRIO_RST = 4'd1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PRIO_W-1:0] prio;
        logic              running;
    } entry_t;

    typedef struct packed {
        logic              have;
        logic [KIND_W-1:0] kind;
        logic [PRIO_W-1:0] prio;
        logic [ACK_W-1:0]  ack;
    } ins_req_t;

    typedef struct packed {
        logic [ACK_W-1:0]     ack_kind;
        logic                 dispatch_valid;
        logic [KIND_W-1:0]    dispatch_task;
        logic [CNT_OUT_W-1:0] queue_count;
        logic                 error_flag;
    } result_t;

endpackage

// ----- design/irq_priority_task_queue.sv -----
// Interrupt task queue: classifies an interrupt event (UART receive, UART
// transmit, core timer), reports the acknowledge, keeps tasks sorted by priority
// (smaller first, FIFO among equals) and dispatches the head when it is not yet
// running; a done beat removes the head. One beat is in work at a time. An event
// that inserts walks from the tail over the entries that sit behind the new task,
// and a done beat on two or more entries shifts the rest down, one entry per
// cycle through the single read and single write port of the entry memory. A
// result that is not taken stalls the block only when the next result is ready.
// No clearing pass after reset: only entries below the fill count are read.
// Depends on irqtq_pkg, irqtq_cfg, irqtq_mem and irqtq_seq.
module irq_priority_task_queue
    import irqtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PRIO_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 action,
    input  logic [31:0]          pending_word,
    input  logic [7:0]           uart_ident,
    input  logic [11:0]          core_source,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ACK_W-1:0]     ack_kind,
    output logic                 dispatch_valid,
    output logic [KIND_W-1:0]    dispatch_task,
    output logic [CNT_OUT_W-1:0] queue_count,
    output logic                 error_flag
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    ins_req_t      req;
    result_t       result;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    entry_t        mem_wdata;
    entry_t        mem_rdata;

    irqtq_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pending_word (pending_word),
        .uart_ident   (uart_ident),
        .core_source  (core_source),
        .req          (req)
    );

    irqtq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    irqtq_seq #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .req       (req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    assign ack_kind       = result.ack_kind;
    assign dispatch_valid = result.dispatch_valid;
    assign dispatch_task  = result.dispatch_task;
    assign queue_count    = result.queue_count;
    assign error_flag     = result.error_flag;

endmodule

// ----- design/irqtq_mem.sv -----
// Entry store of the interrupt task queue: one write and one read port,
// read data registered. Depends on irqtq_pkg.
module irqtq_mem
    import irqtq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/irqtq_cfg.sv -----
// Priority registers and interrupt source classification.
// Turns an event beat into an insert request. Depends on irqtq_pkg.
module irqtq_cfg
    import irqtq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PRIO_W-1:0]    cfg_data,
    input  logic [31:0]          pending_word,
    input  logic [7:0]           uart_ident,
    input  logic [11:0]          core_source,
    output ins_req_t             req
);

    logic [PRIO_W-1:0] rx_prio_reg;
    logic [PRIO_W-1:0] tx_prio_reg;
    logic [PRIO_W-1:0] timer_prio_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_prio_reg    <= RX_PRIO_RST;
            tx_prio_reg    <= TX_PRIO_RST;
            timer_prio_reg <= TIMER_PRIO_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_RX_PRIO:    rx_prio_reg    <= cfg_data;
                CFG_TX_PRIO:    tx_prio_reg    <= cfg_data;
                CFG_TIMER_PRIO: timer_prio_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        req = '{have: 1'b0, kind: KIND_RX, prio: '0, ack: ACK_NONE};
        if (pending_word[UART_PENDING_BIT])
        begin
            if ((uart_ident & UART_RX_IDENT) != '0)
            begin
                req = '{have: 1'b1, kind: KIND_RX, prio: rx_prio_reg, ack: ACK_RX};
            end
            else if ((uart_ident & UART_TX_IDENT) != '0)
            begin
                req = '{have: 1'b1, kind: KIND_TX, prio: tx_prio_reg, ack: ACK_TX};
            end
        end
        else if ((core_source & CORE_TIMER_BIT) != '0)
        begin
            req = '{have: 1'b1, kind: KIND_TIMER, prio: timer_prio_reg, ack: ACK_TIMER};
        end
    end

endmodule

// ----- design/irqtq_seq.sv -----
// Sequencer of the interrupt task queue: sorted insert, head removal and
// head dispatch as read-modify-write walks over the entry store.
// Depends on irqtq_pkg.
module irqtq_seq
    import irqtq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          action,
    input  ins_req_t      req,
    output logic          out_valid,
    input  logic          out_ready,
    output result_t       result,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output entry_t        mem_wdata,
    output logic [AW-1:0] mem_raddr,
    input  entry_t        mem_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_WALK,
        S_INS_PLACE,
        S_POP_WALK,
        S_HEAD_RD,
        S_HEAD_CHK,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [PRIO_W-1:0] prio_reg, prio_next;
    logic [ACK_W-1:0]  ack_reg, ack_next;
    logic              err_reg, err_next;
    logic              disp_reg, disp_next;
    logic [KIND_W-1:0] task_reg, task_next;
    logic              out_valid_reg, out_valid_next;
    result_t           result_reg, result_next;

    logic   accept;
    entry_t new_entry;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign new_entry = '{kind: kind_reg, prio: prio_reg, running: 1'b0};

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        kind_next      = kind_reg;
        prio_next      = prio_reg;
        ack_next       = ack_reg;
        err_next       = err_reg;
        disp_next      = disp_reg;
        task_next      = task_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = new_entry;
        mem_raddr      = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    err_next  = 1'b0;
                    disp_next = 1'b0;
                    task_next = KIND_RX;
                    ack_next  = ACK_NONE;
                    kind_next = req.kind;
                    prio_next = req.prio;
                    state_next = S_HEAD_RD;
                    if (!action)
                    begin
                        ack_next = req.ack;
                        if (req.have)
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                err_next = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                idx_next   = '0;
                                state_next = S_INS_PLACE;
                            end
                            else
                            begin
                                mem_raddr  = AW'(count_reg - CW'(1));
                                idx_next   = AW'(count_reg);
                                state_next = S_INS_WALK;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            err_next = 1'b1;
                        end
                        else if (count_reg == CW'(1))
                        begin
                            count_next = '0;
                        end
                        else
                        begin
                            mem_raddr  = AW'(1);
                            idx_next   = '0;
                            state_next = S_POP_WALK;
                        end
                    end
                end
            end

            S_INS_WALK:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                if (mem_rdata.prio > prio_reg)
                begin
                    mem_wdata = mem_rdata;
                    idx_next  = idx_reg - AW'(1);
                    mem_raddr = idx_reg - AW'(2);
                    if (idx_reg == AW'(1))
                    begin
                        state_next = S_INS_PLACE;
                    end
                end
                else
                begin
                    mem_wdata  = new_entry;
                    count_next = count_reg + CW'(1);
                    state_next = S_HEAD_RD;
                end
            end

            S_INS_PLACE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = new_entry;
                count_next = count_reg + CW'(1);
                state_next = S_HEAD_RD;
            end

            S_POP_WALK:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = mem_rdata;
                mem_raddr = idx_reg + AW'(2);
                if (CW'(idx_reg) + CW'(2) == count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_HEAD_RD;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end

            S_HEAD_RD:
            begin
                mem_raddr  = '0;
                state_next = (count_reg == '0) ? S_DONE : S_HEAD_CHK;
            end

            S_HEAD_CHK:
            begin
                if (!mem_rdata.running)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = '{kind: mem_rdata.kind, prio: mem_rdata.prio,
                                  running: 1'b1};
                    disp_next = 1'b1;
                    task_next = mem_rdata.kind;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    result_next = '{ack_kind:       ack_reg,
                                    dispatch_valid: disp_reg,
                                    dispatch_task:  task_reg,
                                    queue_count:    CNT_OUT_W'(count_reg),
                                    error_flag:     err_reg};
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            kind_reg      <= KIND_RX;
            prio_reg      <= '0;
            ack_reg       <= ACK_NONE;
            err_reg       <= 1'b0;
            disp_reg      <= 1'b0;
            task_reg      <= KIND_RX;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            kind_reg      <= kind_next;
            prio_reg      <= prio_next;
            ack_reg       <= ack_next;
            err_reg       <= err_next;
            disp_reg      <= disp_next;
            task_reg      <= task_next;
            out_valid_reg <= out_valid_next;
            result_reg    <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ----- design/irqtq_checker.sv -----
// Port-level checks for the interrupt task queue, bound to the top level.
// Depends on irqtq_pkg and irq_priority_task_queue.
module irqtq_checker
    import irqtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [ACK_W-1:0]     ack_kind,
    input logic                 dispatch_valid,
    input logic [KIND_W-1:0]    dispatch_task,
    input logic [CNT_OUT_W-1:0] queue_count,
    input logic                 error_flag
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ack_kind)
            && $stable(dispatch_valid) && $stable(dispatch_task)
            && $stable(queue_count) && $stable(error_flag))
        else $error("result beat changed while stalled");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (QUEUE_DEPTH > 15) || (int'(queue_count) <= QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_idle_task: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !dispatch_valid |-> dispatch_task == KIND_RX)
        else $error("task code without dispatch");

    a_dispatch_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dispatch_valid |-> (QUEUE_DEPTH > 15) || (queue_count != '0))
        else $error("dispatch from an empty queue");

    a_empty_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_flag && ack_kind == ACK_NONE
            |-> queue_count == '0 && !dispatch_valid)
        else $error("done on empty left entries or dispatched");

endmodule

bind irq_priority_task_queue irqtq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_irqtq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .ack_kind       (ack_kind),
    .dispatch_valid (dispatch_valid),
    .dispatch_task  (dispatch_task),
    .queue_count    (queue_count),
    .error_flag     (error_flag)
);

// ----- tb/tb_irq_priority_task_queue.sv -----
// Self-checking testbench for irq_priority_task_queue: a directed run, then random
// event/done beats under several priority settings, checked against a local scheduler.
// Depends on irqtq_pkg and the irq_priority_task_queue RTL.
module tb_irq_priority_task_queue;
    import irqtq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = DEPTH + 8;

    localparam logic ACT_EVENT = 1'b0;
    localparam logic ACT_DONE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [31:0] UART_MASK = 32'd1 << UART_PENDING_BIT;

    typedef struct packed {
        logic        action;
        logic [31:0] pending_word;
        logic [7:0]  uart_ident;
        logic [11:0] core_source;
    } beat_t;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_PERIODIC
    } sink_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PRIO_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 action = 1'b0;
    logic [31:0]          pending_word = '0;
    logic [7:0]           uart_ident = '0;
    logic [11:0]          core_source = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [ACK_W-1:0]     ack_kind;
    logic                 dispatch_valid;
    logic [KIND_W-1:0]    dispatch_task;
    logic [CNT_OUT_W-1:0] queue_count;
    logic                 error_flag;

    beat_t   backlog[$];
    beat_t   held_beat;
    result_t due_results[$];

    logic [PRIO_W-1:0] rx_rank;
    logic [PRIO_W-1:0] tx_rank;
    logic [PRIO_W-1:0] timer_rank;
    logic [KIND_W-1:0] slot_kind[DEPTH];
    logic [PRIO_W-1:0] slot_prio[DEPTH];
    logic              slot_run[DEPTH];
    int                fill;

    int         cycles = 0;
    int         mismatches = 0;
    int         beats_sent = 0;
    int         results_seen = 0;
    int         reg_writes = 0;
    int         burst_left = 0;
    int         gap_left = 0;
    bit         load_next;
    sink_mode_t sink_mode = SINK_OPEN;
    int         mode_left = 0;
    result_t    got;
    result_t    want;

    irq_priority_task_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .pending_word(pending_word),
        .uart_ident(uart_ident),
        .core_source(core_source),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .ack_kind(ack_kind),
        .dispatch_valid(dispatch_valid),
        .dispatch_task(dispatch_task),
        .queue_count(queue_count),
        .error_flag(error_flag)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t schedule_beat(input beat_t b);
        result_t           r;
        logic              have;
        logic [KIND_W-1:0] kind;
        logic [PRIO_W-1:0] prio;
        int                pos;
        int                i;
        r = '0;
        have = 1'b0;
        kind = KIND_RX;
        prio = '0;
        if (b.action == ACT_EVENT)
        begin
            if (b.pending_word[UART_PENDING_BIT])
            begin
                if ((b.uart_ident & UART_RX_IDENT) != 0)
                begin
                    r.ack_kind = ACK_RX;
                    kind = KIND_RX;
                    prio = rx_rank;
                    have = 1'b1;
                end
                else if ((b.uart_ident & UART_TX_IDENT) != 0)
                begin
                    r.ack_kind = ACK_TX;
                    kind = KIND_TX;
                    prio = tx_rank;
                    have = 1'b1;
                end
            end
            else if ((b.core_source & CORE_TIMER_BIT) != 0)
            begin
                r.ack_kind = ACK_TIMER;
                kind = KIND_TIMER;
                prio = timer_rank;
                have = 1'b1;
            end
            if (have)
            begin
                if (fill >= DEPTH)
                    r.error_flag = 1'b1;
                else
                begin
                    pos = 0;
                    while (pos < fill && slot_prio[pos] <= prio)
                        pos++;
                    for (i = fill; i > pos; i--)
                    begin
                        slot_kind[i] = slot_kind[i-1];
                        slot_prio[i] = slot_prio[i-1];
                        slot_run[i] = slot_run[i-1];
                    end
                    slot_kind[pos] = kind;
                    slot_prio[pos] = prio;
                    slot_run[pos] = 1'b0;
                    fill++;
                end
            end
        end
        else
        begin
            if (fill == 0)
                r.error_flag = 1'b1;
            else
            begin
                for (i = 0; i + 1 < fill; i++)
                begin
                    slot_kind[i] = slot_kind[i+1];
                    slot_prio[i] = slot_prio[i+1];
                    slot_run[i] = slot_run[i+1];
                end
                fill--;
                slot_run[fill] = 1'b0;
            end
        end
        if (fill > 0 && !slot_run[0])
        begin
            slot_run[0] = 1'b1;
            r.dispatch_valid = 1'b1;
            r.dispatch_task = slot_kind[0];
        end
        r.queue_count = CNT_OUT_W'(fill);
        return r;
    endfunction

    function automatic beat_t make_beat(input logic act, input logic [31:0] pw,
                                        input logic [7:0] ident, input logic [11:0] core);
        beat_t b;
        b.action = act;
        b.pending_word = pw;
        b.uart_ident = ident;
        b.core_source = core;
        return b;
    endfunction

    function automatic beat_t random_beat(input int insert_pct);
        beat_t b;
        b.pending_word = $urandom;
        b.uart_ident = 8'($urandom);
        b.core_source = 12'($urandom);
        b.action = ($urandom_range(99) < insert_pct) ? ACT_EVENT : ACT_DONE;
        if (b.action == ACT_EVENT)
        begin
            case ($urandom_range(9))
                0, 1, 2:
                begin
                    b.pending_word[UART_PENDING_BIT] = 1'b1;
                    b.uart_ident = b.uart_ident | UART_RX_IDENT;
                end
                3, 4, 5:
                begin
                    b.pending_word[UART_PENDING_BIT] = 1'b1;
                    b.uart_ident = (b.uart_ident & ~UART_RX_IDENT) | UART_TX_IDENT;
                end
                6:
                begin
                    b.pending_word[UART_PENDING_BIT] = 1'b1;
                    b.uart_ident = b.uart_ident & ~(UART_RX_IDENT | UART_TX_IDENT);
                end
                7, 8:
                begin
                    b.pending_word[UART_PENDING_BIT] = 1'b0;
                    b.core_source = b.core_source | CORE_TIMER_BIT;
                end
                default:
                begin
                    b.pending_word[UART_PENDING_BIT] = 1'b0;
                    b.core_source = b.core_source & ~CORE_TIMER_BIT;
                end
            endcase
        end
        return b;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PRIO_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_RX_PRIO:    rx_rank = val;
            CFG_TX_PRIO:    tx_rank = val;
            CFG_TIMER_PRIO: timer_rank = val;
            default:        ;
        endcase
        reg_writes++;
    endtask

    task automatic apply_setting(input logic [PRIO_W-1:0] rx_p, input logic [PRIO_W-1:0] tx_p,
                                 input logic [PRIO_W-1:0] timer_p);
        write_reg(CFG_RX_PRIO, rx_p);
        write_reg(CFG_TX_PRIO, tx_p);
        write_reg(CFG_TIMER_PRIO, timer_p);
    endtask

    task automatic wait_idle();
        do
        begin
            while (backlog.size() != 0 || in_valid || due_results.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
        while (backlog.size() != 0 || in_valid || due_results.size() != 0);
    endtask

    task automatic run_phase(input int n, input int insert_pct);
        repeat (n) backlog.push_back(random_beat(insert_pct));
        wait_idle();
    endtask

    // driver: bursts of beats separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            load_next = !in_valid;
            if (in_valid && in_ready)
            begin
                due_results.push_back(schedule_beat(held_beat));
                beats_sent++;
                load_next = 1'b1;
            end
            if (load_next)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (backlog.size() != 0)
                begin
                    held_beat = backlog.pop_front();
                    in_valid <= 1'b1;
                    action <= held_beat.action;
                    pending_word <= held_beat.pending_word;
                    uart_ident <= held_beat.uart_ident;
                    core_source <= held_beat.core_source;
                    if (burst_left <= 1)
                    begin
                        burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 60)
                                                              : $urandom_range(1, 10);
                        gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 14);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: check each result beat, stall on a changing pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.ack_kind = ack_kind;
                got.dispatch_valid = dispatch_valid;
                got.dispatch_task = dispatch_task;
                got.queue_count = queue_count;
                got.error_flag = error_flag;
                if (due_results.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("ack_kind", 32'(want.ack_kind), 32'(got.ack_kind));
                    check_field("dispatch_valid", 32'(want.dispatch_valid),
                                32'(got.dispatch_valid));
                    check_field("dispatch_task", 32'(want.dispatch_task),
                                32'(got.dispatch_task));
                    check_field("queue_count", 32'(want.queue_count), 32'(got.queue_count));
                    check_field("error_flag", 32'(want.error_flag), 32'(got.error_flag));
                    results_seen++;
                end
            end
            if (mode_left == 0)
            begin
                sink_mode = sink_mode_t'($urandom_range(3));
                mode_left = $urandom_range(20, 150);
            end
            else
                mode_left--;
            case (sink_mode)
                SINK_OPEN:     out_ready <= 1'b1;
                SINK_COIN:     out_ready <= 1'($urandom_range(1));
                SINK_SPARSE:   out_ready <= ($urandom_range(3) == 0);
                SINK_PERIODIC: out_ready <= ((cycles % 11) < 3);
                default:       out_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, due_results.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rx_rank = RX_PRIO_RST;
        tx_rank = TX_PRIO_RST;
        timer_rank = TIMER_PRIO_RST;
        fill = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_kind[i] = KIND_RX;
            slot_prio[i] = '0;
            slot_run[i] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset priorities, fill past full, drain past empty
        backlog.push_back(make_beat(ACT_DONE, 32'h0, 8'h00, 12'h000));
        backlog.push_back(make_beat(ACT_EVENT, 32'h0, 8'h00, 12'h000));
        backlog.push_back(make_beat(ACT_EVENT, UART_MASK, 8'hF9, 12'hFFF));
        backlog.push_back(make_beat(ACT_EVENT, UART_MASK, UART_RX_IDENT, 12'h000));
        backlog.push_back(make_beat(ACT_EVENT, 32'h0, 8'h00, CORE_TIMER_BIT));
        backlog.push_back(make_beat(ACT_EVENT, UART_MASK, UART_TX_IDENT, 12'h000));
        backlog.push_back(make_beat(ACT_EVENT, UART_MASK, UART_RX_IDENT | UART_TX_IDENT,
                                    12'h000));
        backlog.push_back(make_beat(ACT_EVENT, 32'hFFFF_FFFF, 8'hFF, 12'hFFF));
        backlog.push_back(make_beat(ACT_EVENT, ~UART_MASK, 8'hFF, 12'hFFF));
        backlog.push_back(make_beat(ACT_EVENT, 32'h0, 8'hFF, CORE_TIMER_BIT));
        backlog.push_back(make_beat(ACT_EVENT, UART_MASK | 32'h1, 8'hFB, 12'h000));
        backlog.push_back(make_beat(ACT_EVENT, UART_MASK, UART_RX_IDENT, 12'h000));
        backlog.push_back(make_beat(ACT_EVENT, 32'h0, 8'h00, CORE_TIMER_BIT));
        backlog.push_back(make_beat(ACT_EVENT, ~UART_MASK, 8'hFF, 12'hFFD));
        repeat (DEPTH + 1) backlog.push_back(make_beat(ACT_DONE, 32'hFFFF_FFFF, 8'hFF, 12'hFFF));
        wait_idle();

        apply_setting(4'd0, 4'd0, 4'd0);
        run_phase(300, 50);
        apply_setting(4'd15, 4'd15, 4'd15);
        run_phase(300, 70);
        apply_setting(4'd15, 4'd0, 4'd7);
        write_reg(CFG_SPARE, 4'd15);
        run_phase(300, 40);
        apply_setting(4'd0, 4'd15, 4'd15);
        write_reg(CFG_SPARE, 4'd0);
        run_phase(300, 60);
        apply_setting(4'($urandom), 4'($urandom), 4'($urandom));
        run_phase(300, 55);
        apply_setting(4'($urandom), 4'($urandom), 4'($urandom));
        run_phase(300, 65);

        if (due_results.size() != 0)
        begin
            $error("%0d expected results never arrived", due_results.size());
            mismatches++;
        end
        $display("covered %0d beats and %0d checked results over seven priority settings",
                 beats_sent, results_seen);
        $display("%0d register writes, %0d mismatches", reg_writes, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
design/irqtq_pkg.sv
design/irqtq_mem.sv
design/irqtq_cfg.sv
design/irqtq_seq.sv
design/irq_priority_task_queue.sv
design/irqtq_checker.sv
tb/tb_irq_priority_task_queue.sv
